// ===== hdl/b64d_pkg.sv =====
// Shared types and constants for the base64 stream decoder.
package b64d_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 4;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;

   localparam logic [15:0] MAX_OUT_RESET = 16'hFFFF;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_MAX_OUT = 3'd0;

   // Final status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_INVAL = 2'd1;
   localparam logic [1:0] STATUS_SIZE  = 2'd2;

   typedef enum logic [1:0] {
      KIND_SEXTET,
      KIND_PAD,
      KIND_BAD
   } b64d_kind_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } b64d_req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_status;
      logic [1:0]  status;
      logic [15:0] byte_count;
      logic        end_of_run;
   } b64d_rsp_type;

   // One classified character, as queued between front and back.
   typedef struct packed {
      b64d_kind_type kind;
      logic [5:0]    sextet;
      logic          last;
   } b64d_entry_type;

   // Queue head handed to the back end.
   typedef struct packed {
      logic           valid;
      b64d_entry_type entry;
   } b64d_head_type;

endpackage

// ===== hdl/b64d_front.sv =====
// Front end: character classification and the item queue.
module b64d_front import b64d_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  b64d_req_type  req_payload,
   output b64d_head_type head,
   input  logic          pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   b64d_entry_type   q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full_ff, full_in;
   b64d_entry_type   new_entry;
   logic [7:0]       diff;
   logic             push;
   logic             do_pop;

   // Character to sextet
   always_comb begin
      new_entry.last   = req_payload.last;
      new_entry.kind   = KIND_SEXTET;
      new_entry.sextet = 6'd0;
      diff             = 8'd0;
      priority if (req_payload.char_code >= "A" && req_payload.char_code <= "Z") begin
         diff             = req_payload.char_code - 8'("A");
         new_entry.sextet = diff[5:0];
      end else if (req_payload.char_code >= "a" && req_payload.char_code <= "z") begin
         diff             = req_payload.char_code - 8'("a") + 8'd26;
         new_entry.sextet = diff[5:0];
      end else if (req_payload.char_code >= "0" && req_payload.char_code <= "9") begin
         diff             = req_payload.char_code - 8'("0") + 8'd52;
         new_entry.sextet = diff[5:0];
      end else if (req_payload.char_code == 8'("+")) begin
         new_entry.sextet = 6'd62;
      end else if (req_payload.char_code == 8'("/")) begin
         new_entry.sextet = 6'd63;
      end else if (req_payload.char_code == 8'("=")) begin
         new_entry.kind = KIND_PAD;
      end else begin
         new_entry.kind = KIND_BAD;
      end
   end

   assign req_stall = full_ff;
   assign push      = req_valid && !full_ff;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      full_in = (count_in == CNT_FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         full_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         full_ff   <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = q_ff[rd_ptr_ff];

endmodule

// ===== hdl/b64d_back.sv =====
// Back end: bit packing, error tracking, status and output register.
module b64d_back import b64d_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  b64d_head_type head,
   output logic          pop,
   input  logic [15:0]   max_out_bytes,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output b64d_rsp_type  rsp_payload
);

   // Stream state
   logic [5:0]            lb_ff, lb_in;
   logic [2:0]            lc_ff, lc_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [1:0]            lmod_ff, lmod_in;
   logic [1:0]            pmod_ff, pmod_in;
   logic                  padp_ff, padp_in;
   logic [1:0]            err_ff, err_in;

   // Output register: optional byte, then optional status
   logic                  obv_ff;
   logic                  osv_ff;
   logic [7:0]            obyte_ff;
   logic [1:0]            ostat_ff;
   logic [15:0]           ocount_ff;

   logic [11:0]           acc;
   logic [7:0]            byte_val;
   logic [5:0]            lb_keep;
   logic                  out_full;
   logic                  emit_byte;
   logic [1:0]            st;
   logic [31:0]           cnt_wide;
   logic                  rsp_accept;
   logic                  stage_free;
   b64d_entry_type        e;

   assign e          = head.entry;
   assign acc        = {lb_ff, e.sextet};
   assign out_full   = (cnt_ff == '1) || (32'(cnt_ff) >= 32'(max_out_bytes));
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign stage_free = (!obv_ff && !osv_ff) || (rsp_accept && !(obv_ff && osv_ff));
   assign pop        = head.valid && stage_free;

   // Byte extraction by how many bits were left over
   always_comb begin
      unique case (lc_ff)
         3'd4: begin
            byte_val = acc[9:2];
            lb_keep  = {4'd0, acc[1:0]};
         end
         3'd6: begin
            byte_val = acc[11:4];
            lb_keep  = {2'd0, acc[3:0]};
         end
         default: begin
            byte_val = acc[7:0];
            lb_keep  = 6'd0;
         end
      endcase
   end

   always_comb begin
      lb_in     = lb_ff;
      lc_in     = lc_ff;
      cnt_in    = cnt_ff;
      lmod_in   = lmod_ff;
      pmod_in   = pmod_ff;
      padp_in   = padp_ff;
      err_in    = err_ff;
      emit_byte = 1'b0;
      st        = STATUS_OK;
      if (e.kind == KIND_PAD) begin
         padp_in = 1'b1;
         pmod_in = pmod_ff + 2'd1;
      end else begin
         lmod_in = lmod_ff + pmod_ff + 2'd1;
         padp_in = 1'b0;
         pmod_in = 2'd0;
         // pad run followed by data
         if (padp_ff && err_ff == STATUS_OK) begin
            err_in = STATUS_INVAL;
         end
         if (err_in == STATUS_OK) begin
            if (e.kind == KIND_BAD) begin
               err_in = STATUS_INVAL;
            end else if (lc_ff >= 3'd2) begin
               if (out_full) begin
                  err_in = STATUS_SIZE;
               end else begin
                  emit_byte = 1'b1;
                  cnt_in    = cnt_ff + COUNT_BITS'(1);
               end
               lb_in = lb_keep;
               lc_in = lc_ff - 3'd2;
            end else begin
               lb_in = e.sextet;
               lc_in = 3'd6;
            end
         end
      end
      st = (lmod_in == 2'd1) ? STATUS_INVAL : err_in;
      cnt_wide = 32'(cnt_in);
      if (e.last) begin
         lb_in   = 6'd0;
         lc_in   = 3'd0;
         cnt_in  = '0;
         lmod_in = 2'd0;
         pmod_in = 2'd0;
         padp_in = 1'b0;
         err_in  = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lb_ff   <= 6'd0;
         lc_ff   <= 3'd0;
         cnt_ff  <= '0;
         lmod_ff <= 2'd0;
         pmod_ff <= 2'd0;
         padp_ff <= 1'b0;
         err_ff  <= STATUS_OK;
         obv_ff  <= 1'b0;
         osv_ff  <= 1'b0;
      end else begin
         if (pop) begin
            lb_ff   <= lb_in;
            lc_ff   <= lc_in;
            cnt_ff  <= cnt_in;
            lmod_ff <= lmod_in;
            pmod_ff <= pmod_in;
            padp_ff <= padp_in;
            err_ff  <= err_in;
            obv_ff  <= emit_byte;
            osv_ff  <= e.last;
         end else if (rsp_accept) begin
            if (obv_ff) begin
               obv_ff <= 1'b0;
            end else begin
               osv_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         obyte_ff  <= byte_val;
         ostat_ff  <= st;
         ocount_ff <= cnt_wide[15:0];
      end
   end

   assign rsp_valid              = obv_ff || osv_ff;
   assign rsp_payload.out_byte   = obv_ff ? obyte_ff : 8'd0;
   assign rsp_payload.is_status  = !obv_ff;
   assign rsp_payload.status     = obv_ff ? STATUS_OK : ostat_ff;
   assign rsp_payload.byte_count = obv_ff ? 16'd0 : ocount_ff;
   assign rsp_payload.end_of_run = !obv_ff;

endmodule

// ===== hdl/base64_stream_decoder_top.sv =====
// Top level of the base64 stream decoder: register port and front/back wiring.
//
// Usage notes
// - req channel: one ASCII character per item (char_code) plus last, which
//   marks the final character of an encoded message.
// - rsp channel: a decoded byte item (is_status 0) whenever 8 bits are ready,
//   and on a last character a status item (is_status 1, end_of_run 1) with the
//   status code and the byte count. A last character that completes a byte
//   gives the byte first, then the status.
// - Status: ok, invalid argument (bad character, '=' followed by data, or a
//   stripped length of 1 mod 4) or size (more bytes than max_out_bytes).
//   After the first error no more bytes come out for that message.
// - csr port: register max_out_bytes at byte address 0, reset 65535. Write
//   it only while no item is in flight.
// - An accepted item passes through the queue, then the output register.
// - Throughput: 1 item per cycle while rsp_stall is low; an item that yields
//   both a byte and a status holds the output register until both are taken.
// - A 4-entry queue sits between classifier and packer; req_stall rises when it
//   fills while rsp_stall or byte-plus-status items hold the output register.
// - Reset (synchronous) empties the queue and output register and clears
//   the stream state; the decoder is ready the cycle after.
module base64_stream_decoder_top import b64d_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // character input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  b64d_req_type          req_payload,
   // decoded output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output b64d_rsp_type          rsp_payload,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [15:0]   max_out_ff;
   logic          csr_hit;
   logic          csr_wr;
   b64d_head_type head;
   logic          pop;

   // Word-aligned decode: bit 2 selects the register, low bits are ignored.
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_ADDR_MAX_OUT[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? {16'd0, max_out_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_out_ff <= MAX_OUT_RESET;
      end else if (csr_wr) begin
         max_out_ff <= csr_pwdata[15:0];
      end
   end

   // Classify and queue incoming characters
   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .head        (head),
      .pop         (pop)
   );

   // Pack sextets into bytes, track errors, drive the output register
   b64d_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .max_out_bytes (max_out_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the base64 stream decoder: predictor, drivers and checks.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::*;

   localparam logic [7:0] PAD_CHAR      = 8'h3D;   // '='
   localparam int         RESET_CYCLES  = 7;
   localparam int         SETTLE_CYCLES = 8;       // lets items that owe no result finish
   localparam int         CYCLE_LIMIT   = 200000;
   localparam int         HOLD_CYCLES   = 100;     // long output back-pressure
   localparam int         HOLD_AFTER    = 120;     // results seen before the hold starts
   localparam int         IDLE_PCT      = 37;
   localparam int         MAX_REPORTS   = 10;

   // Shapes of generated messages: mostly clean encodings, the rest damaged.
   typedef enum {MSG_CLEAN, MSG_BROKEN, MSG_NOISE, MSG_SHORT} msg_shape_type;

   // Tracks the decoder state per message and holds the decoded bytes and
   // status items still owed by the block, oldest first.
   class decode_scoreboard_type;
      logic [15:0]  out_cap;
      logic [5:0]   carry_bits;
      int           carry_cnt;
      logic [15:0]  emitted;
      logic [1:0]   len_mod4;
      logic [1:0]   pad_run_mod4;
      bit           pad_open;
      logic [1:0]   first_err;
      b64d_rsp_type expected_q[$];
      int           bad_results;

      function new();
         out_cap     = MAX_OUT_RESET;
         bad_results = 0;
         clear_message();
      endfunction

      function void clear_message();
         carry_bits   = '0;
         carry_cnt    = 0;
         emitted      = '0;
         len_mod4     = '0;
         pad_run_mod4 = '0;
         pad_open     = 1'b0;
         first_err    = STATUS_OK;
      endfunction

      function int sextet_value(logic [7:0] ch);
         if (ch >= "A" && ch <= "Z") return int'(ch) - int'("A");
         if (ch >= "a" && ch <= "z") return int'(ch) - int'("a") + 26;
         if (ch >= "0" && ch <= "9") return int'(ch) - int'("0") + 52;
         if (ch == "+") return 62;
         if (ch == "/") return 63;
         return -1;
      endfunction

      function void note_input(b64d_req_type item);
         b64d_rsp_type r;
         int           v;
         int           acc;
         int           nbits;
         logic [1:0]   st;
         if (item.char_code == PAD_CHAR) begin
            pad_open     = 1'b1;
            pad_run_mod4 = pad_run_mod4 + 2'd1;
         end else begin
            // a pad run followed by data still counts toward the length
            len_mod4 = len_mod4 + pad_run_mod4 + 2'd1;
            if (pad_open && first_err == STATUS_OK) first_err = STATUS_INVAL;
            pad_open     = 1'b0;
            pad_run_mod4 = '0;
            if (first_err == STATUS_OK) begin
               v = sextet_value(item.char_code);
               if (v < 0) begin
                  first_err = STATUS_INVAL;
               end else begin
                  acc   = (int'(carry_bits) << 6) | v;
                  nbits = carry_cnt + 6;
                  if (nbits >= 8) begin
                     nbits -= 8;
                     if (emitted >= out_cap) begin
                        first_err = STATUS_SIZE;
                     end else begin
                        r          = '0;
                        r.out_byte = 8'((acc >> nbits) & 'hFF);
                        expected_q.push_back(r);
                        emitted++;
                     end
                     carry_bits = 6'(acc & ((1 << nbits) - 1));
                  end else begin
                     carry_bits = 6'(acc);
                  end
                  carry_cnt = nbits;
               end
            end
         end
         if (item.last) begin
            st = first_err;
            if (len_mod4 == 2'd1) st = STATUS_INVAL;
            r            = '0;
            r.is_status  = 1'b1;
            r.status     = st;
            r.byte_count = emitted;
            r.end_of_run = 1'b1;
            expected_q.push_back(r);
            clear_message();
         end
      endfunction

      function void check_result(b64d_rsp_type got);
         b64d_rsp_type want;
         if (expected_q.size() == 0) begin
            bad_results++;
            if (bad_results <= MAX_REPORTS)
               $display("%0t unexpected result: byte %02h st_item %0d status %0d count %0d eor %0d",
                        $time, got.out_byte, got.is_status, got.status, got.byte_count,
                        got.end_of_run);
            return;
         end
         want = expected_q.pop_front();
         if (got.out_byte !== want.out_byte || got.is_status !== want.is_status ||
             got.status !== want.status || got.byte_count !== want.byte_count ||
             got.end_of_run !== want.end_of_run) begin
            bad_results++;
            if (bad_results <= MAX_REPORTS)
               $display({"%0t mismatch: want byte %02h st_item %0d status %0d count %0d eor %0d",
                         " / got byte %02h st_item %0d status %0d count %0d eor %0d"},
                        $time, want.out_byte, want.is_status, want.status, want.byte_count,
                        want.end_of_run, got.out_byte, got.is_status, got.status,
                        got.byte_count, got.end_of_run);
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // Clock, reset and block hookup
   // ---------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   b64d_req_type          req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   b64d_rsp_type          rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   decode_scoreboard_type sb = new();

   bit         no_idle      = 1'b0;  // both sides run flat out while set
   int         items_sent   = 0;
   int         results_seen = 0;
   int         csr_errors   = 0;
   int         cycle_count  = 0;
   logic [7:0] msg_chars[$];         // message being assembled for sending

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   base64_stream_decoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Hard stop in case the block hangs or drops results.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[base64_stream_decoder_top] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Result side: samples at each edge (pre-update values), then picks the next
   // stall. Once, after HOLD_AFTER results, it holds off for HOLD_CYCLES so the
   // internal queue fills and req_stall has to rise.
   // ---------------------------------------------------------------------------
   initial begin : result_sink
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_payload);
            results_seen++;
         end
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Character side
   // ---------------------------------------------------------------------------

   // Offers one item; idle cycles come before it at random. Returns in the time
   // step of acceptance, so the caller's next drive is the only one that step.
   task automatic send_item(b64d_req_type item);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(item);
      items_sent++;
   endtask

   // Sends msg_chars as one message, last set on the final character.
   task automatic send_message();
      b64d_req_type item;
      foreach (msg_chars[i]) begin
         item.char_code = msg_chars[i];
         item.last      = (i == msg_chars.size() - 1);
         send_item(item);
      end
   endtask

   function automatic void load_string(string s);
      msg_chars.delete();
      for (int i = 0; i < s.len(); i++) msg_chars.push_back(s[i]);
   endfunction

   function automatic logic [7:0] alphabet_char(int v);
      if (v < 26) return 8'(int'("A") + v);
      if (v < 52) return 8'(int'("a") + v - 26);
      if (v < 62) return 8'(int'("0") + v - 52);
      if (v == 62) return "+";
      return "/";
   endfunction

   // Random message: clean encodings (with, without or with short padding),
   // encodings with one defect, raw byte noise, or a length of 1 mod 4.
   function automatic void build_message();
      msg_shape_type shape;
      int            pick;
      int            quads;
      int            tail;
      int            pos;
      msg_chars.delete();
      pick  = $urandom_range(0, 9);
      shape = (pick < 7) ? MSG_CLEAN : (pick == 7) ? MSG_BROKEN :
              (pick == 8) ? MSG_NOISE : MSG_SHORT;
      case (shape)
         MSG_NOISE: begin
            repeat ($urandom_range(1, 8)) msg_chars.push_back(8'($urandom_range(0, 255)));
         end
         MSG_SHORT: begin
            repeat (4 * $urandom_range(0, 3) + 1)
               msg_chars.push_back(alphabet_char($urandom_range(0, 63)));
            if ($urandom_range(0, 1)) msg_chars.push_back(PAD_CHAR);
         end
         default: begin
            quads = $urandom_range(0, 4);
            repeat (quads * 4) msg_chars.push_back(alphabet_char($urandom_range(0, 63)));
            tail = $urandom_range(0, 3);
            if (tail == 1) begin
               repeat (2) msg_chars.push_back(alphabet_char($urandom_range(0, 63)));
               repeat (2) msg_chars.push_back(PAD_CHAR);
            end else if (tail == 2) begin
               repeat (3) msg_chars.push_back(alphabet_char($urandom_range(0, 63)));
               msg_chars.push_back(PAD_CHAR);
            end else if (tail == 3) begin
               // unpadded tail
               repeat ($urandom_range(2, 3))
                  msg_chars.push_back(alphabet_char($urandom_range(0, 63)));
            end
            // nothing to encode: an all-padding message
            if (msg_chars.size() == 0)
               repeat ($urandom_range(1, 3)) msg_chars.push_back(PAD_CHAR);
            if (shape == MSG_BROKEN) begin
               pos = $urandom_range(0, msg_chars.size() - 1);
               case ($urandom_range(0, 2))
                  0:       msg_chars[pos] = 8'($urandom_range(0, 255));
                  1:       msg_chars.insert(pos, PAD_CHAR);
                  default: msg_chars.delete(pos);
               endcase
               if (msg_chars.size() == 0) msg_chars.push_back(alphabet_char($urandom_range(0, 63)));
            end
         end
      endcase
   endfunction

   task automatic run_random(int item_target);
      int start;
      start = items_sent;
      while (items_sent - start < item_target) begin
         build_message();
         send_message();
      end
   endtask

   // Drops valid (same step as the last acceptance), waits for every owed
   // result, then gives the block time to finish items that owe nothing.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Register port: setup cycle, then access cycle until pready, then psel drops
   // so the next access starts in a later step
   // ---------------------------------------------------------------------------
   task automatic csr_access(logic write, logic [CSR_ADDR_W-1:0] addr,
                             logic [CSR_DATA_W-1:0] wdata, output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // New output capacity between messages, with read-back.
   task automatic set_capacity(logic [15:0] cap);
      logic [CSR_DATA_W-1:0] rdata;
      drain();
      csr_access(1'b1, CSR_ADDR_MAX_OUT, CSR_DATA_W'(cap), rdata);
      csr_access(1'b0, CSR_ADDR_MAX_OUT, '0, rdata);
      if (rdata[15:0] !== cap) begin
         csr_errors++;
         $display("%0t max_out_bytes read back %0h, wrote %0h", $time, rdata, cap);
      end
      sb.out_cap = cap;
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset capacity: full quad, one- and two-pad tails,
      // all-padding message, pad followed by data, length 1 mod 4, alphabet
      // edges, then a bad code 0x00 and code 0xFF carrying last.
      load_string("TWFu");
      send_message();
      load_string("QQ==");
      send_message();
      load_string("QUI=");
      send_message();
      load_string("=");
      send_message();
      load_string("QQ=A");
      send_message();
      load_string("Q");
      send_message();
      load_string("AZaz09+/");
      msg_chars.push_back(8'h00);
      msg_chars.push_back(8'hFF);
      send_message();

      // Random traffic at the reset capacity, with a flat-out stretch in
      // the middle; the long output hold also lands in this phase.
      run_random(200);
      no_idle = 1'b1;
      run_random(100);
      no_idle = 1'b0;
      run_random(60);

      // Zero capacity: every byte is a size error.
      set_capacity(16'd0);
      load_string("TWFu");
      send_message();
      run_random(60);

      // Tiny capacity: output runs out mid-message.
      set_capacity(16'd2);
      load_string("TWFuTWFu");
      send_message();
      set_capacity(16'($urandom_range(1, 8)));
      run_random(180);

      // Maximum capacity, written explicitly.
      set_capacity(16'hFFFF);
      run_random(150);

      drain();
      if (sb.bad_results == 0 && csr_errors == 0) begin
         $display("[base64_stream_decoder_top] OK");
      end else begin
         $display("[base64_stream_decoder_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== base64_stream_decoder_top.f =====
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_back.sv
hdl/base64_stream_decoder_top.sv
tb/tb_top.sv
